[rtl/wtsg_pkg.sv]
`default_nettype none

package wtsg_pkg;

  // Table geometry. The table length equals the Q14 unit, so a step of one
  // index moves the ramps by exactly one LSB.
  localparam int unsigned TABLE_LENGTH = 16384;
  localparam int unsigned IDX_W        = $clog2(TABLE_LENGTH);
  localparam int unsigned HALF_LEN     = TABLE_LENGTH / 2;

  // Sample format
  localparam int unsigned SAMPLE_W = 16;
  localparam logic signed [SAMPLE_W-1:0] Q14_ONE   = 16'sd16384;
  localparam logic signed [SAMPLE_W-1:0] Q14_M_ONE = -16'sd16384;

  // Wave shape codes
  localparam logic [2:0] SHAPE_SINE     = 3'd0;
  localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
  localparam logic [2:0] SHAPE_SQUARE   = 3'd2;
  localparam logic [2:0] SHAPE_RAMP_UP  = 3'd3;
  localparam logic [2:0] SHAPE_RAMP_DN  = 3'd4;
  localparam logic [2:0] SHAPE_CONST    = 3'd5;
  localparam logic [2:0] SHAPE_PULSE    = 3'd6;

  // Register map
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FREQ_W   = 26;
  localparam int unsigned RATIO_W  = 17;
  localparam int unsigned TRANS_W  = 14;
  localparam logic [1:0] REG_SHAPE = 2'd0;
  localparam logic [1:0] REG_FREQ  = 2'd1;
  localparam logic [1:0] REG_RATIO = 2'd2;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd32768;

  // Square edge length: floor(freq * 3 / 10000) by a reciprocal, exact for
  // any product below 2^28.
  localparam int unsigned FREQ_X3_W   = FREQ_W + 2;
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = 42;
  localparam logic [RECIP_W-1:0] RECIP_M = 29'd439804652;
  localparam int unsigned TRANS_MIN_RAW = 10;
  localparam int unsigned TRANS_SHORT   = 30;

  // Sine polynomial in Q30
  localparam int unsigned Q30_W = 31;
  localparam logic [Q30_W-1:0] SIN_C1 = 31'd1686629713;
  localparam logic [Q30_W-1:0] SIN_C3 = 31'd693598668;
  localparam logic [Q30_W-1:0] SIN_C5 = 31'd85569306;
  localparam logic [Q30_W-1:0] SIN_C7 = 31'd5026995;
  localparam logic [Q30_W-1:0] SIN_C9 = 31'd172272;
  localparam int unsigned SIN_TERMS = 4;
  // Coefficients subtracted at each Horner step, first step at index 0
  localparam logic [SIN_TERMS-1:0][Q30_W-1:0] SIN_COEF = {SIN_C1, SIN_C3, SIN_C5, SIN_C7};
  localparam int unsigned SINE_DONE_STAGE = 7;

  // Edge divider: 16 quotient bits, one per stage
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_NUM_W = TRANS_W + DIV_STEPS - 2;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Start of an accepted item to its result strobe
  localparam int unsigned RESULT_LATENCY = DIV_STEPS + 3;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_SINE,
    KIND_EDGE
  } kind_e;

  // Per-item control travelling along the back pipeline
  typedef struct packed {
    kind_e                       kind;
    logic                        neg;
    logic signed [SAMPLE_W-1:0]  val;
    logic [IDX_W:0]              u;
  } meta_t;

  typedef struct packed {
    meta_t                       meta;
    logic [DIV_NUM_W-1:0]        num;
    logic [TRANS_W-1:0]          den;
  } item_t;

  typedef struct packed {
    logic [2:0]                  shape;
    logic [TRANS_W-1:0]          trans;
    logic [TRANS_W-1:0]          pulse_h;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/wtsg_cfg.sv]
`default_nettype none

module wtsg_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [wtsg_pkg::DATA_W-1:0]   pwdata,
  output logic [wtsg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output wtsg_pkg::cfg_t                cfg_o
);
  import wtsg_pkg::*;

  logic [2:0]                 shape_q;
  logic [FREQ_W-1:0]          freq_q;
  logic [RATIO_W-1:0]         ratio_q;
  logic [TRANS_W-1:0]         trans_q, trans_d;
  logic                       wr_en;
  logic [1:0]                 reg_sel;
  logic [FREQ_X3_W-1:0]       freq_x3;
  logic [FREQ_X3_W+RECIP_W-1:0] recip_prod;
  logic [FREQ_X3_W+RECIP_W-RECIP_SHIFT-1:0] trans_raw;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Edge length from the written frequency, worked out on the write transfer.
  always_comb begin
    freq_x3    = FREQ_X3_W'(pwdata[FREQ_W-1:0]) + (FREQ_X3_W'(pwdata[FREQ_W-1:0]) << 1);
    recip_prod = (FREQ_X3_W+RECIP_W)'(freq_x3) * (FREQ_X3_W+RECIP_W)'(RECIP_M);
    trans_raw  = recip_prod[FREQ_X3_W+RECIP_W-1:RECIP_SHIFT];
    if (trans_raw <= $bits(trans_raw)'(TRANS_MIN_RAW)) begin
      trans_d = TRANS_W'(TRANS_SHORT);
    end else if (trans_raw > $bits(trans_raw)'(HALF_LEN)) begin
      trans_d = TRANS_W'(HALF_LEN);
    end else begin
      trans_d = trans_raw[TRANS_W-1:0];
    end
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_SINE;
      freq_q  <= '0;
      ratio_q <= RATIO_RESET;
      trans_q <= TRANS_W'(TRANS_SHORT);
    end else if (wr_en) begin
      case (reg_sel)
        REG_SHAPE: shape_q <= pwdata[2:0];
        REG_FREQ: begin
          freq_q  <= pwdata[FREQ_W-1:0];
          trans_q <= trans_d;
        end
        REG_RATIO: ratio_q <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_SHAPE: prdata = DATA_W'(shape_q);
      REG_FREQ:  prdata = DATA_W'(freq_q);
      REG_RATIO: prdata = DATA_W'(ratio_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.shape   = shape_q;
  assign cfg_o.trans   = trans_q;
  assign cfg_o.pulse_h = ratio_q[RATIO_W-1:3];

endmodule

`default_nettype wire

[rtl/wtsg_front.sv]
`default_nettype none

module wtsg_front (
  input  logic                         start,
  input  logic [wtsg_pkg::IDX_W-1:0]   table_index_i,
  input  wtsg_pkg::cfg_t               cfg_i,
  input  logic                         q_full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output wtsg_pkg::item_t              item_o
);
  import wtsg_pkg::*;

  localparam logic signed [IDX_W+3:0] N_S  = (IDX_W+4)'(TABLE_LENGTH);
  localparam logic signed [IDX_W+3:0] N2_S = (IDX_W+4)'(2 * TABLE_LENGTH);
  localparam logic signed [IDX_W+3:0] N3_S = (IDX_W+4)'(3 * TABLE_LENGTH);
  localparam logic signed [IDX_W+3:0] N4_S = (IDX_W+4)'(4 * TABLE_LENGTH);

  logic [IDX_W-1:0]        idx;
  logic [1:0]              quad;
  logic [IDX_W-1:0]        rem4;
  logic [IDX_W:0]          sin_u;
  logic signed [IDX_W+3:0] f_s;
  logic signed [IDX_W+3:0] tri_v;
  logic [TRANS_W-1:0]      half_minus;
  logic [IDX_W:0]          n_minus;
  logic [IDX_W:0]          edge_d;
  logic [IDX_W:0]          pulse_sum;

  assign idx    = table_index_i;
  assign busy_o = q_full_i;
  assign push_o = start & ~q_full_i;

  // Sine quadrant folding
  assign quad  = idx[IDX_W-1:IDX_W-2];
  assign rem4  = {idx[IDX_W-3:0], 2'b00};
  assign sin_u = quad[0] ? ((IDX_W+1)'(TABLE_LENGTH) - {1'b0, rem4}) : {1'b0, rem4};

  // Triangle: the rising and falling flanks meet at a quarter and three quarters.
  always_comb begin
    f_s = (IDX_W+4)'({idx, 2'b00});
    if (f_s <= N_S) begin
      tri_v = f_s;
    end else if (f_s <= N3_S) begin
      tri_v = N2_S - f_s;
    end else begin
      tri_v = f_s - N4_S;
    end
  end

  assign half_minus = TRANS_W'(HALF_LEN) - cfg_i.trans;
  assign n_minus    = (IDX_W+1)'(TABLE_LENGTH) - (IDX_W+1)'(cfg_i.trans);
  assign pulse_sum  = (IDX_W+1)'(idx) + (IDX_W+1)'(cfg_i.pulse_h);

  // Classify the item and prepare what the back end needs.
  always_comb begin
    item_o.meta.kind = KIND_DIRECT;
    item_o.meta.neg  = 1'b0;
    item_o.meta.val  = '0;
    item_o.meta.u    = sin_u;
    item_o.num       = '0;
    item_o.den       = cfg_i.trans;
    edge_d           = '0;
    case (cfg_i.shape)
      SHAPE_SINE: begin
        item_o.meta.kind = KIND_SINE;
        item_o.meta.neg  = quad[1];
      end
      SHAPE_TRIANGLE: item_o.meta.val = tri_v[SAMPLE_W-1:0];
      SHAPE_SQUARE: begin
        if (idx < half_minus) begin
          item_o.meta.val = Q14_ONE;
        end else if ((IDX_W+1)'(idx) < (IDX_W+1)'(HALF_LEN)) begin
          item_o.meta.kind = KIND_EDGE;
          item_o.meta.neg  = 1'b1;
          item_o.meta.val  = Q14_ONE;
          edge_d           = (IDX_W+1)'(idx) - (IDX_W+1)'(half_minus);
        end else if ((IDX_W+1)'(idx) < n_minus) begin
          item_o.meta.val = Q14_M_ONE;
        end else begin
          item_o.meta.kind = KIND_EDGE;
          item_o.meta.val  = Q14_M_ONE;
          edge_d           = (IDX_W+1)'(idx) - n_minus;
        end
        item_o.num = (DIV_NUM_W'(edge_d) << 15) + DIV_NUM_W'(cfg_i.trans >> 1);
      end
      SHAPE_RAMP_UP: begin
        if (idx == IDX_W'(TABLE_LENGTH - 1)) begin
          item_o.meta.val = '0;
        end else begin
          item_o.meta.val = SAMPLE_W'(idx) + SAMPLE_W'(2);
        end
      end
      SHAPE_RAMP_DN: item_o.meta.val = SAMPLE_W'(TABLE_LENGTH) - SAMPLE_W'(idx);
      SHAPE_CONST:   item_o.meta.val = Q14_ONE;
      SHAPE_PULSE: begin
        if ((idx < cfg_i.pulse_h) || (pulse_sum >= (IDX_W+1)'(TABLE_LENGTH))) begin
          item_o.meta.val = Q14_ONE;
        end else begin
          item_o.meta.val = Q14_M_ONE;
        end
      end
      default: item_o.meta.val = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/wtsg_fifo.sv]
`default_nettype none

module wtsg_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wtsg_pkg::item_t  item_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output wtsg_pkg::item_t  head_o
);
  import wtsg_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/wtsg_back.sv]
`default_nettype none

module wtsg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  wtsg_pkg::item_t                     item_i,
  output logic                                pop_o,
  output logic                                sample_valid_o,
  output logic signed [wtsg_pkg::SAMPLE_W-1:0] sample_value_o
);
  import wtsg_pkg::*;

  localparam int unsigned PROD_W = 2 * Q30_W;

  logic                        valid_q [DIV_STEPS+1];
  meta_t                       meta_q  [DIV_STEPS+1];
  logic [TRANS_W-1:0]          rem_q   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]        nq_q    [DIV_STEPS+1];
  logic [TRANS_W-1:0]          den_q   [DIV_STEPS+1];
  logic [TRANS_W-1:0]          rem_d   [DIV_STEPS];
  logic [DIV_STEPS-1:0]        nq_d    [DIV_STEPS];
  logic [TRANS_W:0]            trial   [DIV_STEPS];

  logic [Q30_W-1:0]            x2_q [SIN_TERMS];
  logic [Q30_W-1:0]            p_q  [SIN_TERMS];
  logic [Q30_W-1:0]            p_d  [SIN_TERMS];
  logic [PROD_W-1:0]           hprod [SIN_TERMS];
  logic [Q30_W-1:0]            s_q;
  logic [2*(IDX_W+1)-1:0]      usq;
  logic [Q30_W-1:0]            x2_d;
  logic [Q30_W-1:0]            x_in;
  logic [PROD_W-1:0]           sprod;
  logic [Q30_W:0]              s_round;
  logic [SAMPLE_W-1:0]         v_raw;
  logic [SAMPLE_W-1:0]         v_lim;
  logic signed [SAMPLE_W-1:0]  sine_val;
  meta_t                       sine_meta;
  logic signed [SAMPLE_W+1:0]  edge_val;

  logic                        out_valid_q;
  logic signed [SAMPLE_W-1:0]  out_value_q;

  // The queue never has to wait: an item is taken as soon as it is there.
  assign pop_o = in_valid_i;

  // Edge divider, one restoring step per stage.
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_q[k], nq_q[k][DIV_STEPS-1]};
      if (trial[k] >= {1'b0, den_q[k]}) begin
        rem_d[k] = TRANS_W'(trial[k] - {1'b0, den_q[k]});
        nq_d[k]  = {nq_q[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][TRANS_W-1:0];
        nq_d[k]  = {nq_q[k][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // Sine: square of the folded angle, Horner steps, final product and rounding.
  always_comb begin
    usq  = (2*(IDX_W+1))'(meta_q[0].u) * (2*(IDX_W+1))'(meta_q[0].u);
    x2_d = Q30_W'({usq, 2'b00});
    for (int k = 0; k < SIN_TERMS; k++) begin
      if (k == 0) begin
        hprod[k] = PROD_W'(x2_q[k]) * PROD_W'(SIN_C9);
      end else begin
        hprod[k] = PROD_W'(x2_q[k]) * PROD_W'(p_q[k-1]);
      end
      p_d[k] = SIN_COEF[k] - hprod[k][PROD_W-2:Q30_W-1];
    end
    x_in  = Q30_W'({meta_q[SINE_DONE_STAGE-2].u, 16'b0});
    sprod = PROD_W'(x_in) * PROD_W'(p_q[SIN_TERMS-1]);
    s_round = (Q30_W+1)'(s_q) + (Q30_W+1)'(32768);
    v_raw   = s_round[Q30_W:16];
    v_lim   = (v_raw > SAMPLE_W'(Q14_ONE)) ? SAMPLE_W'(Q14_ONE) : v_raw;
    sine_val = meta_q[SINE_DONE_STAGE-1].neg ? -$signed(v_lim) : $signed(v_lim);
    // A sine item takes its value here; other items pass unchanged.
    sine_meta = meta_q[SINE_DONE_STAGE-1];
    if (meta_q[SINE_DONE_STAGE-1].kind == KIND_SINE) begin
      sine_meta.val = sine_val;
    end
  end

  // Result of a square edge: level plus or minus the rounded quotient
  assign edge_val = (SAMPLE_W+2)'(meta_q[DIV_STEPS].val)
                  + (meta_q[DIV_STEPS].neg ? -$signed({2'b00, nq_q[DIV_STEPS]})
                                           :  $signed({2'b00, nq_q[DIV_STEPS]}));

  // Pipeline data path
  always_ff @(posedge clk_i) begin
    meta_q[0] <= item_i.meta;
    rem_q[0]  <= TRANS_W'(item_i.num[DIV_NUM_W-1:DIV_STEPS]);
    nq_q[0]   <= item_i.num[DIV_STEPS-1:0];
    den_q[0]  <= item_i.den;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (k == SINE_DONE_STAGE) begin
        meta_q[k] <= sine_meta;
      end else begin
        meta_q[k] <= meta_q[k-1];
      end
      rem_q[k]  <= rem_d[k-1];
      nq_q[k]   <= nq_d[k-1];
      den_q[k]  <= den_q[k-1];
    end
    x2_q[0] <= x2_d;
    for (int k = 1; k < SIN_TERMS; k++) begin
      x2_q[k] <= x2_q[k-1];
    end
    for (int k = 0; k < SIN_TERMS; k++) begin
      p_q[k] <= p_d[k];
    end
    s_q <= sprod[PROD_W-2:Q30_W-1];
    if (meta_q[DIV_STEPS].kind == KIND_EDGE) begin
      out_value_q <= edge_val[SAMPLE_W-1:0];
    end else begin
      out_value_q <= meta_q[DIV_STEPS].val;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        valid_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
      out_valid_q <= valid_q[DIV_STEPS];
    end
  end

  assign sample_valid_o = out_valid_q;
  assign sample_value_o = out_value_q;

endmodule

`default_nettype wire

[rtl/waveform_table_sample_generator_unit.sv]
`default_nettype none

// Waveform table sample generator. Give a table index with start and the
// matching entry of the configured one-period waveform (Q14, 16384 = 1.0)
// appears on sample_value_o, marked by sample_valid_o for one cycle, after
// the queue and the back pipeline. A new index may be given in every cycle;
// the depth is set by the 16-stage divider that shapes the square-wave
// edges, and the other shapes are delayed to match, so results always leave
// in order. The result has no back-pressure: it must be taken in the cycle
// it is shown. busy only rises if the two-entry queue between the front and
// back ends is full, which does not happen since the back end drains it
// every cycle. Configuration writes are for idle periods only.
module waveform_table_sample_generator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [wtsg_pkg::IDX_W-1:0]           table_index_i,
  output logic                                 sample_valid_o,
  output logic signed [wtsg_pkg::SAMPLE_W-1:0] sample_value_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wtsg_pkg::ADDR_W-1:0]          paddr,
  input  logic [wtsg_pkg::DATA_W-1:0]          pwdata,
  output logic [wtsg_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import wtsg_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  q_full, q_empty, push, pop;

  // Configuration registers
  wtsg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front end: accept and classify
  wtsg_front u_front (
    .start         (start),
    .table_index_i (table_index_i),
    .cfg_i         (cfg),
    .q_full_i      (q_full),
    .busy_o        (busy),
    .push_o        (push),
    .item_o        (front_item)
  );

  // Queue between the two ends
  wtsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_item)
  );

  // Back end: sine, edge division and result register
  wtsg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (~q_empty),
    .item_i         (head_item),
    .pop_o          (pop),
    .sample_valid_o (sample_valid_o),
    .sample_value_o (sample_value_o)
  );

endmodule

`default_nettype wire

[rtl/wtsg_checker.sv]
`default_nettype none

module wtsg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 sample_valid_o,
  input logic signed [wtsg_pkg::SAMPLE_W-1:0] sample_value_o
);
  import wtsg_pkg::*;

  // Every transfer gives its result after the fixed pipeline depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##RESULT_LATENCY sample_valid_o)
    else $error("result missing after a start transfer");

  // Every result comes from an earlier transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> $past(start && !busy, RESULT_LATENCY))
    else $error("result without a start transfer");

  // Samples stay within plus and minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> (sample_value_o >= Q14_M_ONE && sample_value_o <= Q14_ONE))
    else $error("sample out of range");

  // The back end drains the queue every cycle, so busy never rises.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

endmodule

bind waveform_table_sample_generator_unit wtsg_checker u_wtsg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .sample_valid_o (sample_valid_o),
  .sample_value_o (sample_value_o)
);

`default_nettype wire

[tb/tb_waveform_table_sample_generator_unit.sv]
`default_nettype none

module tb_waveform_table_sample_generator_unit;
  import wtsg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SHAPE_UNUSED = 7;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [IDX_W-1:0]             table_index_i;
  logic                         sample_valid_o;
  logic signed [SAMPLE_W-1:0]   sample_value_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ADDR_W-1:0]            paddr;
  logic [DATA_W-1:0]            pwdata;
  logic [DATA_W-1:0]            prdata;
  logic                         pready;

  // Shadow copy of the configuration registers.
  logic [2:0]                   cur_shape;
  logic [FREQ_W-1:0]            cur_freq;
  logic [RATIO_W-1:0]           cur_ratio;

  logic [IDX_W-1:0]             pending_indexes[$];
  logic signed [SAMPLE_W-1:0]   expected_samples[$];
  int                           error_count;
  int                           cycle_count;
  int                           send_idle_pct;
  logic                         sending;

  waveform_table_sample_generator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .table_index_i  (table_index_i),
    .sample_valid_o (sample_valid_o),
    .sample_value_o (sample_value_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sine by quadrant folding and a Horner-evaluated Taylor series in Q30.
  function automatic logic signed [SAMPLE_W-1:0] sine_sample(input longint unsigned idx);
    longint unsigned n, q, r, u, x, x2, p, s, v;
    n = TABLE_LENGTH;
    q = (4 * idx) / n;
    r = (4 * idx) % n;
    u = q[0] ? (n - r) : r;
    x = ((u << 30) + n / 2) / n;
    x2 = (x * x) >> 30;
    p = SIN_C9;
    p = SIN_C7 - ((x2 * p) >> 30);
    p = SIN_C5 - ((x2 * p) >> 30);
    p = SIN_C3 - ((x2 * p) >> 30);
    p = SIN_C1 - ((x2 * p) >> 30);
    s = (x * p) >> 30;
    v = (s + (64'd1 << 15)) >> 16;
    if (v > 16384) v = 16384;
    return (q >= 2) ? -SAMPLE_W'(v) : SAMPLE_W'(v);
  endfunction

  // Works out the table entry for one index under the current settings.
  function automatic logic signed [SAMPLE_W-1:0] waveform_sample(input logic [IDX_W-1:0] index);
    longint n, i, f, half, trans, h, v;
    n = TABLE_LENGTH;
    i = index % n;
    half = n / 2;
    v = 0;
    case (cur_shape)
      SHAPE_SINE: v = sine_sample(i);
      SHAPE_TRIANGLE: begin
        f = 4 * i;
        if (f <= n) v = (f * 16384 + n / 2) / n;
        else if (f <= 2 * n) v = ((2 * n - f) * 16384 + n / 2) / n;
        else if (f <= 3 * n) v = -(((f - 2 * n) * 16384 + n / 2) / n);
        else v = -(((4 * n - f) * 16384 + n / 2) / n);
      end
      SHAPE_SQUARE: begin
        trans = (longint'(cur_freq) * 300) / 1000000;
        if (trans <= 10) trans = 30;
        if (trans > half) trans = half;
        if (i < half - trans) v = 16384;
        else if (i < half)
          v = 16384 - ((i - (half - trans)) * 32768 + trans / 2) / trans;
        else if (i < n - trans) v = -16384;
        else v = -16384 + ((i - (n - trans)) * 32768 + trans / 2) / trans;
      end
      SHAPE_RAMP_UP: v = (i + 1 < n) ? ((i + 2) * 16384 + n / 2) / n : 0;
      SHAPE_RAMP_DN: v = ((n - i) * 16384 + n / 2) / n;
      SHAPE_CONST: v = 16384;
      SHAPE_PULSE: begin
        h = (half * longint'(cur_ratio)) >> 16;
        v = (i < h || i + h >= n) ? 16384 : -16384;
      end
      default: v = 0;
    endcase
    return SAMPLE_W'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_register(input logic [1:0] reg_sel, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'({reg_sel, 2'b00}); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_sel)
      REG_SHAPE: cur_shape = value[2:0];
      REG_FREQ:  cur_freq  = value[FREQ_W-1:0];
      REG_RATIO: cur_ratio = value[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every expected sample has arrived, plus the pipeline depth.
  task automatic drain_pipeline();
    wait (pending_indexes.size() == 0 && !sending);
    wait (expected_samples.size() == 0);
    repeat (RESULT_LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic queue_indexes(input int count, input bit edge_heavy);
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < count; k++) begin
      if (edge_heavy && $urandom_range(3) == 0)
        idx = IDX_W'(HALF_LEN - 40 + $urandom_range(80) +
                     ($urandom_range(1) ? HALF_LEN : 0));
      else
        idx = IDX_W'($urandom);
      pending_indexes.push_back(idx);
    end
  endtask

  // Driver: presents the next index with start, idling at random while items remain.
  always @(negedge clk_i) begin
    if (rst_ni && !busy && start) sending = 1'b0;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_indexes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        table_index_i <= pending_indexes.pop_front();
        start <= 1'b1;
        sending = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each start transfer and checks each strobed sample.
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    cycle_count++;
    if (rst_ni) begin
      if (start && !busy)
        expected_samples.push_back(waveform_sample(table_index_i));
      if (sample_valid_o) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", sample_value_o));
        end else begin
          want = expected_samples.pop_front();
          if (sample_value_o !== want)
            report_mismatch($sformatf("sample_value got %0d want %0d",
                                      sample_value_o, want));
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] freqs[6];
    logic [DATA_W-1:0] ratios[5];
    error_count = 0; cycle_count = 0; send_idle_pct = 30; sending = 1'b0;
    start = 1'b0; table_index_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur_shape = SHAPE_SINE; cur_freq = '0; cur_ratio = RATIO_RESET;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: table ends, quadrant points and the index MSB on reset settings.
    pending_indexes = '{14'd0, 14'd1, 14'd4095, 14'd4096, 14'd8191, 14'd8192,
                        14'd12288, 14'd16382, 14'd16383, 14'h2AAA, 14'h1555};
    drain_pipeline();
    for (int s = 0; s <= SHAPE_UNUSED; s++) begin
      write_register(REG_SHAPE, DATA_W'(s));
      pending_indexes = '{14'd0, 14'd4096, 14'd8191, 14'd8192, 14'd16383};
      drain_pipeline();
    end

    // Random part over many settings, extremes among them.
    freqs  = '{0, 36666, 36667, 1000000, 27306667, 62500000};
    ratios = '{0, 1, 32768, 65536, 131071};
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 79 : 0;
      for (int s = 0; s <= SHAPE_UNUSED; s++) begin
        write_register(REG_SHAPE, DATA_W'(s));
        if (s == SHAPE_SQUARE) begin
          for (int k = 0; k < 6; k++) begin
            write_register(REG_FREQ, (k == 2 && phase == 2) ?
                           DATA_W'($urandom_range(62500000)) : freqs[k]);
            queue_indexes(10, 1'b1);
            drain_pipeline();
          end
        end else if (s == SHAPE_PULSE) begin
          for (int k = 0; k < 5; k++) begin
            write_register(REG_RATIO, (k == 2 && phase == 2) ?
                           DATA_W'($urandom_range(131071)) : ratios[k]);
            queue_indexes(10, 1'b1);
            drain_pipeline();
          end
        end else begin
          queue_indexes(s == SHAPE_UNUSED ? 15 : 48, 1'b0);
          drain_pipeline();
        end
      end
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
